// ===== rtl/core/iiss_pkg.sv =====
// Shared widths, register codes, types and helpers for the integral image block.
package iiss_pkg;

  localparam int PIXEL_W   = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = 30;
  localparam int SQ_W      = 38;
  localparam int ROW_SUM_W = 19;
  localparam int ROW_SQ_W  = 27;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic [CFG_W-1:0] RESET_LINE_WIDTH   = 12'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic first_row;
    logic frame_last;
  } scan_ctl_t;

  // Last valid index for a size register: zero acts as one, large values clamp to limit.
  function automatic logic [CFG_W:0] last_index(input logic [CFG_W-1:0] v, input int limit);
    logic [CFG_W:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > limit) begin
      res = (CFG_W + 1)'(limit - 1);
    end else begin
      res = {1'b0, v} - 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/iiss_scan.sv =====
// Raster position counters and per-row running sums of pixels and squared pixels.
module iiss_scan import iiss_pkg::*; #(
  parameter int CW = 11,
  parameter int RW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [PIXEL_W-1:0]   pixel,
  input  logic [CW-1:0]        width_last,
  input  logic [RW-1:0]        height_last,
  output logic [CW-1:0]        col,
  output logic [ROW_SUM_W-1:0] row_sum_new,
  output logic [ROW_SQ_W-1:0]  row_sq_new,
  output scan_ctl_t            ctl
);

  logic [RW-1:0]          row;
  logic [ROW_SUM_W-1:0]   row_sum;
  logic [ROW_SQ_W-1:0]    row_sq;
  logic [2*PIXEL_W-1:0]   px_sq;
  logic                   row_end;
  logic                   frame_end;

  assign px_sq       = (2*PIXEL_W)'(pixel) * (2*PIXEL_W)'(pixel);
  assign row_sum_new = row_sum + ROW_SUM_W'(pixel);
  assign row_sq_new  = row_sq + ROW_SQ_W'(px_sq);
  assign row_end     = (col >= width_last);
  assign frame_end   = row_end && (row >= height_last);

  assign ctl.first_row  = (row == '0);
  assign ctl.frame_last = frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      row_sum <= '0;
      row_sq  <= '0;
    end else if (accept) begin
      if (row_end) begin
        col     <= '0;
        row_sum <= '0;
        row_sq  <= '0;
        row     <= frame_end ? '0 : row + 1'b1;
      end else begin
        col     <= col + 1'b1;
        row_sum <= row_sum_new;
        row_sq  <= row_sq_new;
      end
    end
  end

endmodule

// ===== rtl/core/iiss_accum.sv =====
// Line store of previous-row integrals with read-modify-write, forwarding and output register.
module iiss_accum import iiss_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CW        = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [CW-1:0]        col,
  input  logic [ROW_SUM_W-1:0] row_sum_new,
  input  logic [ROW_SQ_W-1:0]  row_sq_new,
  input  scan_ctl_t            ctl,
  input  logic                 out_stall,
  output logic                 s1_busy,
  output logic                 out_valid,
  output logic [SUM_W-1:0]     integral_sum,
  output logic [SQ_W-1:0]      integral_square_sum,
  output logic                 frame_last
);

  logic [SUM_W-1:0] sum_mem [MAX_WIDTH];
  logic [SQ_W-1:0]  sq_mem  [MAX_WIDTH];

  logic                 s1_valid;
  logic [CW-1:0]        s1_col;
  logic [ROW_SUM_W-1:0] s1_row_sum;
  logic [ROW_SQ_W-1:0]  s1_row_sq;
  scan_ctl_t            s1_ctl;
  logic [SUM_W-1:0]     rd_sum;
  logic [SQ_W-1:0]      rd_sq;
  logic                 fwd_hit;
  logic [SUM_W-1:0]     fwd_sum;
  logic [SQ_W-1:0]      fwd_sq;

  logic                 s1_fire;
  logic [SUM_W-1:0]     prev_sum;
  logic [SQ_W-1:0]      prev_sq;
  logic [SUM_W-1:0]     new_sum;
  logic [SQ_W-1:0]      new_sq;

  assign s1_busy = s1_valid;
  assign s1_fire = s1_valid && (!out_valid || !out_stall);

  // Previous row: zero on the first row, forwarded if the write ahead lands on this read's edge.
  always_comb begin
    if (s1_ctl.first_row) begin
      prev_sum = '0;
      prev_sq  = '0;
    end else if (fwd_hit) begin
      prev_sum = fwd_sum;
      prev_sq  = fwd_sq;
    end else begin
      prev_sum = rd_sum;
      prev_sq  = rd_sq;
    end
  end

  assign new_sum = SUM_W'(s1_row_sum) + prev_sum;
  assign new_sq  = SQ_W'(s1_row_sq) + prev_sq;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_sum <= sum_mem[col];
      rd_sq  <= sq_mem[col];
    end
    if (s1_fire) begin
      sum_mem[s1_col] <= new_sum;
      sq_mem[s1_col]  <= new_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= col;
      s1_row_sum <= row_sum_new;
      s1_row_sq  <= row_sq_new;
      s1_ctl     <= ctl;
      fwd_hit    <= s1_fire && (s1_col == col);
      fwd_sum    <= new_sum;
      fwd_sq     <= new_sq;
    end
    if (s1_fire) begin
      integral_sum        <= new_sum;
      integral_square_sum <= new_sq;
      frame_last          <= s1_ctl.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/integral_image_sum_and_square.sv =====
// Top level of the integral image block: configuration, handshake and stage wiring.
//
// Streams 8-bit pixels in raster order and returns, per pixel, the summed-area value and
// the summed-area value of squared pixels; frame_last marks the final pixel of each frame.
// One pixel per clock is sustained while out_stall is low; an accepted pixel is registered
// with its line store read, then added into the output register as its result.
// The line store is one synchronous memory per sum, read and written once per pixel, with
// forwarding when consecutive pixels hit the same column. It needs no clearing pass: the
// first row adds zero in place of its read. Write line_width and frame_height only between
// transactions; a zero value acts as one and values above MAX_WIDTH or MAX_HEIGHT clamp.
module integral_image_sum_and_square import iiss_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIXEL_W-1:0]   pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SUM_W-1:0]     integral_sum,
  output logic [SQ_W-1:0]      integral_square_sum,
  output logic                 frame_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam logic [CFG_W:0] RESET_W_LAST = last_index(RESET_LINE_WIDTH, MAX_WIDTH);
  localparam logic [CFG_W:0] RESET_H_LAST = last_index(RESET_FRAME_HEIGHT, MAX_HEIGHT);

  logic [CW-1:0]        width_last;
  logic [RW-1:0]        height_last;
  logic [CFG_W:0]       cfg_w_last;
  logic [CFG_W:0]       cfg_h_last;
  logic                 accept;
  logic                 s1_busy;
  logic [CW-1:0]        col;
  logic [ROW_SUM_W-1:0] row_sum_new;
  logic [ROW_SQ_W-1:0]  row_sq_new;
  scan_ctl_t            ctl;

  assign cfg_ready  = 1'b1;
  assign cfg_w_last = last_index(cfg_data, MAX_WIDTH);
  assign cfg_h_last = last_index(cfg_data, MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= RESET_W_LAST[CW-1:0];
      height_last <= RESET_H_LAST[RW-1:0];
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_WIDTH:   width_last  <= cfg_w_last[CW-1:0];
        REG_FRAME_HEIGHT: height_last <= cfg_h_last[RW-1:0];
        default: ;
      endcase
    end
  end

  // Hold input only when the compute stage is full and the output cannot drain.
  assign in_stall = s1_busy && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  iiss_scan #(
    .CW(CW),
    .RW(RW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixel      (pixel),
    .width_last (width_last),
    .height_last(height_last),
    .col        (col),
    .row_sum_new(row_sum_new),
    .row_sq_new (row_sq_new),
    .ctl        (ctl)
  );

  iiss_accum #(
    .MAX_WIDTH(MAX_WIDTH),
    .CW       (CW)
  ) u_accum (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .col                (col),
    .row_sum_new        (row_sum_new),
    .row_sq_new         (row_sq_new),
    .ctl                (ctl),
    .out_stall          (out_stall),
    .s1_busy            (s1_busy),
    .out_valid          (out_valid),
    .integral_sum       (integral_sum),
    .integral_square_sum(integral_square_sum),
    .frame_last         (frame_last)
  );

`ifndef SYNTHESIS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_busy)
    else $error("accepted transaction did not reach the compute stage");

  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_busy && !out_valid) |=> out_valid)
    else $error("compute stage held while the output register was empty");

  a_single_pixel_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && width_last == '0 && height_last == '0) |-> frame_last)
    else $error("one-pixel frame result not marked as frame end");
`endif

endmodule
